// ===== hdl/rgba8_tile_swizzle_core_defines.svh =====
// Assertion macros shared by the tile swizzle RTL.
`ifndef RGBA8_TILE_SWIZZLE_CORE_DEFINES_SVH
`define RGBA8_TILE_SWIZZLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`define RTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define RTS_ASSERT_IMP(label, clk, rstn, ante, cons)

`define RTS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/rts_pkg.sv =====
`timescale 1ns / 1ps
package rts_pkg;

    localparam int TILE_DIM   = 4;
    localparam int PIX_W      = 32;
    localparam int PAIR_W     = 16;
    localparam int WORD_W     = 64;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 11;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 72;

    localparam logic [IDX_W-1:0] LAST_WORD   = 3'd7;
    localparam logic [1:0]       LAST_ROW    = 2'd3;
    localparam logic [1:0]       LAST_LANE   = 2'd3;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SETTLE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [1:0]       rd_row;
        logic [IDX_W-1:0] emit_idx;
    } cmd_t;

    typedef struct packed {
        logic tile_pos;
    } status_t;

endpackage

// ===== hdl/rgba8_tile_swizzle_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_        in         one ARGB pixel, row-major order
// m_        out        one tiled 64-bit word, eight beats per 4x4 tile
// cfg_      in         image width in pixels
//
// A pixel that does not complete a tile is written straight into the band memory.
// The pixel that completes a tile is followed by four reads of the four-lane band memory, a settle
// state for the last read data, and eight output beats, each of which can stall on m_tready.
// Reset is synchronous and active low; it clears the position and sets the width to 640.
// The band memory is not cleared and needs a full band before its first tile.
`include "rgba8_tile_swizzle_core_defines.svh"
module rgba8_tile_swizzle_core
    import rts_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // alpha [7:0], red [15:8], green [23:16], blue [31:24]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tile_word [63:0], word_index [66:64], zero [71:67]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    cmd_t    cmd;
    status_t status;

    rts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    rts_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    `RTS_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready && !cmd.rd_en)
    `RTS_ASSERT_NEXT(a_tile_starts, aclk, aresetn, s_tvalid && s_tready && status.tile_pos, !s_tready && !m_tvalid && cmd.rd_en)
    `RTS_ASSERT_NEXT(a_back_to_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

// ===== hdl/rts_ram.sv =====
`timescale 1ns / 1ps
module rts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rts_ctrl.sv =====
`timescale 1ns / 1ps
module rts_ctrl
    import rts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic    m_tlast,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                if (s_tvalid && status.tile_pos) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == LAST_ROW) begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE: begin
                cnt_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (m_tready) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_WORD) begin
                        state_next = S_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tlast      = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_row   = cnt_reg[1:0];
        cmd.emit_idx = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.wr_en = s_tvalid;
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
            end
            S_SETTLE: begin
                cmd.rd_en = 1'b0;
            end
            S_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = (cnt_reg == LAST_WORD);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/rts_datapath.sv =====
`timescale 1ns / 1ps
module rts_datapath
    import rts_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    input  cmd_t                cmd,
    output status_t             status
);

    localparam int CW         = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int EW         = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int QUADS      = MAX_WIDTH / TILE_DIM;
    localparam int LANE_DEPTH = TILE_DIM * QUADS;
    localparam int AW         = $clog2(LANE_DEPTH);
    localparam logic [EW-1:0] MIN_W   = EW'(TILE_DIM);
    localparam logic [EW-1:0] MAX_W   = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MAX_RND = EW'(QUADS * TILE_DIM);

    logic [CFG_W-1:0] width_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [1:0]       row_reg, row_next;
    logic [AW-1:0]    slot_reg;
    logic             rd_valid_reg;
    logic [1:0]       rd_row_d_reg;
    logic [PIX_W-1:0] tile_buf_reg [TILE_DIM][TILE_DIM];

    logic [EW-1:0]    width_masked;
    logic [EW-1:0]    eff_width;
    logic             row_end;
    logic [AW-1:0]    cur_slot;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] lane_rdata [TILE_DIM];
    logic [WORD_W-1:0] tile_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_valid) begin
            width_reg <= cfg_data;
        end
    end

    always_comb begin
        width_masked = EW'(width_reg) & ~EW'(3);
        if (width_masked < MIN_W) begin
            eff_width = MIN_W;
        end else if (width_masked > MAX_W) begin
            eff_width = MAX_RND;
        end else begin
            eff_width = width_masked;
        end
    end

    assign row_end = (EW'(col_reg) + EW'(1)) >= eff_width;

    always_comb begin
        if (row_end) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.wr_en) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    assign status.tile_pos = (row_reg == LAST_ROW) && (col_reg[1:0] == LAST_LANE);

    assign cur_slot = AW'(col_reg >> 2);
    assign waddr    = AW'(AW'(row_reg) * AW'(QUADS)) + cur_slot;
    assign raddr    = AW'(AW'(cmd.rd_row) * AW'(QUADS)) + slot_reg;
    assign pixel    = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            slot_reg <= cur_slot;
        end
        rd_row_d_reg <= cmd.rd_row;
        if (rd_valid_reg) begin
            for (int i = 0; i < TILE_DIM; i++) begin
                tile_buf_reg[rd_row_d_reg][i] <= lane_rdata[i];
            end
        end
    end

    for (genvar g = 0; g < TILE_DIM; g++) begin : g_lane
        rts_ram #(
            .WIDTH (PIX_W),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (cmd.wr_en && (col_reg[1:0] == 2'(g))),
            .waddr (waddr),
            .wdata (pixel),
            .re    (cmd.rd_en),
            .raddr (raddr),
            .rdata (lane_rdata[g])
        );
    end

    always_comb begin
        tile_word = '0;
        for (int i = 0; i < TILE_DIM; i++) begin
            if (cmd.emit_idx[2]) begin
                tile_word[WORD_W-1-PAIR_W*i -: PAIR_W] =
                    tile_buf_reg[cmd.emit_idx[1:0]][i][PAIR_W-1:0];
            end else begin
                tile_word[WORD_W-1-PAIR_W*i -: PAIR_W] =
                    tile_buf_reg[cmd.emit_idx[1:0]][i][PIX_W-1:PAIR_W];
            end
        end
    end

    assign m_tdata = {{(M_DATA_W - WORD_W - IDX_W){1'b0}}, cmd.emit_idx, tile_word};

endmodule
